/* sv/lsfb_pkg.sv */
// Shared types and constants for the LED strip frame buffer streamer.
// Holds command codes, frame layout constants and the controller-to-datapath command struct.
// No dependencies.
package lsfb_pkg;

    localparam int OP_W    = 3;
    localparam int ENTRY_W = 29;
    localparam int FRAME_W = 32;
    localparam int INDEX_W = 5;
    localparam int COLOR_W = 8;
    localparam int BRIGHT_W = 5;

    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
    localparam logic [OP_W-1:0] OP_SET     = 3'd1;
    localparam logic [OP_W-1:0] OP_COMMIT  = 3'd2;
    localparam logic [OP_W-1:0] OP_SAVE    = 3'd3;
    localparam logic [OP_W-1:0] OP_RESTORE = 3'd4;

    // Every LED frame starts with three ones ahead of the brightness field.
    localparam logic [FRAME_W-ENTRY_W-1:0] FRAME_TAG = 3'b111;

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [FRAME_W-1:0] frame_t;

    typedef struct packed {
        logic clear;          // zero the working buffer
        logic set_entry;      // write the command's color into one working entry
        logic rd_work;        // read the working buffer at the sweep address
        logic rd_saved;       // read the saved buffer at the sweep address
        logic copy_to_saved;  // the working read goes on into the saved buffer
        logic copy_to_work;   // the saved read goes on into the working buffer
        logic emit;           // load a frame into the output register
        logic emit_led;       // the frame carries the entry read in the previous cycle
        logic emit_last;      // the frame ends the commit sequence
    } lsfb_cmd_t;

endpackage

/* sv/led_strip_frame_buffer_streamer.sv */
// LED strip frame buffer streamer: a command is taken when start is high and
// busy is low. Clear and set color leave busy low, so the next command may follow
// at once. Commit puts out LED_COUNT + 2 + ceil(LED_COUNT/64) frames, one
// 32-bit frame per cycle on frame_word, marked by frame_strobe. The first frame
// reaches the port through the state register and the output register, and the
// final frame, marked by last_frame, is on the port in the first cycle in which
// busy is low. The receiver cannot stall, so it must take a beat on every strobe.
// Save and restore sweep the buffers one entry per cycle through the memory read
// port. Both buffers read as zero after reset.
// Depends on lsfb_pkg, lsfb_ctrl, lsfb_datapath and lsfb_ram.
module led_strip_frame_buffer_streamer #(
    parameter int LED_COUNT = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [lsfb_pkg::OP_W-1:0]      operation,
    input  logic [lsfb_pkg::INDEX_W-1:0]   led_index,
    input  logic [lsfb_pkg::COLOR_W-1:0]   red,
    input  logic [lsfb_pkg::COLOR_W-1:0]   green,
    input  logic [lsfb_pkg::COLOR_W-1:0]   blue,
    input  logic [lsfb_pkg::BRIGHT_W-1:0]  brightness,
    output logic [lsfb_pkg::FRAME_W-1:0]   frame_word,
    output logic                           last_frame,
    output logic                           frame_strobe
);

    import lsfb_pkg::*;

    localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    lsfb_cmd_t     cmd;
    logic [AW-1:0] addr;

    lsfb_ctrl #(
        .LED_COUNT (LED_COUNT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .busy      (busy),
        .cmd       (cmd),
        .addr      (addr)
    );

    lsfb_datapath #(
        .LED_COUNT (LED_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .addr         (addr),
        .led_index    (led_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .brightness   (brightness),
        .frame_word   (frame_word),
        .last_frame   (last_frame),
        .frame_strobe (frame_strobe)
    );

endmodule

/* sv/lsfb_ram.sv */
// Generic single-write, single-read memory with a registered read port.
// Used for both color buffers; no dependencies.
module lsfb_ram #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/lsfb_datapath.sv */
// Datapath of the LED strip frame buffer streamer: both color buffers, their
// valid bits, the copy pipeline stage and the frame output register.
// Depends on lsfb_pkg and lsfb_ram.
module lsfb_datapath #(
    parameter int LED_COUNT = 32
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  lsfb_pkg::lsfb_cmd_t                               cmd,
    input  logic [((LED_COUNT > 1) ? $clog2(LED_COUNT) : 1)-1:0] addr,
    input  logic [lsfb_pkg::INDEX_W-1:0]                      led_index,
    input  logic [lsfb_pkg::COLOR_W-1:0]                      red,
    input  logic [lsfb_pkg::COLOR_W-1:0]                      green,
    input  logic [lsfb_pkg::COLOR_W-1:0]                      blue,
    input  logic [lsfb_pkg::BRIGHT_W-1:0]                     brightness,
    output logic [lsfb_pkg::FRAME_W-1:0]                      frame_word,
    output logic                                              last_frame,
    output logic                                              frame_strobe
);

    import lsfb_pkg::*;

    localparam int AW    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int IDX_X = 7;

    logic [LED_COUNT-1:0] work_valid_reg;
    logic [LED_COUNT-1:0] saved_valid_reg;

    logic          pend_work_reg;
    logic          pend_saved_reg;
    logic [AW-1:0] pend_addr_reg;
    logic          work_vq_reg;
    logic          saved_vq_reg;

    logic [IDX_X-1:0] idx_ext;
    logic             set_ok;
    logic [AW-1:0]    set_addr;
    entry_t           set_data;

    entry_t work_rdata;
    entry_t saved_rdata;
    entry_t work_entry;
    entry_t saved_entry;

    logic          work_we;
    logic [AW-1:0] work_waddr;
    entry_t        work_wdata;

    frame_t frame_reg;
    logic   last_reg;
    logic   strobe_reg;

    assign idx_ext  = {{(IDX_X - INDEX_W){1'b0}}, led_index};
    assign set_ok   = cmd.set_entry && (idx_ext < IDX_X'(LED_COUNT));
    assign set_addr = idx_ext[AW-1:0];
    assign set_data = {brightness, blue, green, red};

    // An entry that has not been written since reset or clear reads as zero.
    assign work_entry  = work_vq_reg ? work_rdata : '0;
    assign saved_entry = saved_vq_reg ? saved_rdata : '0;

    assign work_we    = set_ok || pend_work_reg;
    assign work_waddr = pend_work_reg ? pend_addr_reg : set_addr;
    assign work_wdata = pend_work_reg ? saved_entry : set_data;

    lsfb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LED_COUNT)
    ) u_work_ram (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .re    (cmd.rd_work),
        .raddr (addr),
        .rdata (work_rdata)
    );

    lsfb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LED_COUNT)
    ) u_saved_ram (
        .clk   (clk),
        .we    (pend_saved_reg),
        .waddr (pend_addr_reg),
        .wdata (work_entry),
        .re    (cmd.rd_saved),
        .raddr (addr),
        .rdata (saved_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg  <= '0;
            saved_valid_reg <= '0;
            pend_work_reg   <= 1'b0;
            pend_saved_reg  <= 1'b0;
            strobe_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                work_valid_reg <= '0;
            end
            else
            begin
                if (set_ok)
                begin
                    work_valid_reg[set_addr] <= 1'b1;
                end
                if (pend_work_reg)
                begin
                    work_valid_reg[pend_addr_reg] <= 1'b1;
                end
            end
            if (pend_saved_reg)
            begin
                saved_valid_reg[pend_addr_reg] <= 1'b1;
            end
            pend_work_reg  <= cmd.copy_to_work;
            pend_saved_reg <= cmd.copy_to_saved;
            strobe_reg     <= cmd.emit;
        end
    end

    // Payload registers: the read address and valid bits travel with the read.
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= addr;
        if (cmd.rd_work)
        begin
            work_vq_reg <= work_valid_reg[addr];
        end
        if (cmd.rd_saved)
        begin
            saved_vq_reg <= saved_valid_reg[addr];
        end
        if (cmd.emit)
        begin
            frame_reg <= cmd.emit_led ? {FRAME_TAG, work_entry} : '0;
            last_reg  <= cmd.emit_last;
        end
    end

    assign frame_word   = frame_reg;
    assign last_frame   = last_reg;
    assign frame_strobe = strobe_reg;

    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.set_entry && pend_work_reg))
        else $error("set write collides with a restore write");

    a_copy_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.copy_to_saved |=> pend_saved_reg && $past(cmd.rd_work))
        else $error("save copy without a working read");

    a_led_frame_tagged: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_strobe && frame_word != '0) |-> (frame_word[FRAME_W-1 -: 3] == FRAME_TAG))
        else $error("nonzero frame without the LED tag");

endmodule

/* sv/lsfb_ctrl.sv */
// Controller of the LED strip frame buffer streamer: decodes commands and
// sequences the commit, save and restore sweeps over the buffers.
// Depends on lsfb_pkg.
module lsfb_ctrl #(
    parameter int LED_COUNT = 32
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              start,
    input  logic [lsfb_pkg::OP_W-1:0]                         operation,
    output logic                                              busy,
    output lsfb_pkg::lsfb_cmd_t                               cmd,
    output logic [((LED_COUNT > 1) ? $clog2(LED_COUNT) : 1)-1:0] addr
);

    import lsfb_pkg::*;

    localparam int AW     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int TAIL   = (LED_COUNT + 63) / 64;
    localparam int FRAMES = LED_COUNT + 2 + TAIL;
    localparam int CW     = $clog2(FRAMES);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_COMMIT  = 2'd1;
    localparam logic [1:0] S_SAVE    = 2'd2;
    localparam logic [1:0] S_RESTORE = 2'd3;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          in_buf;
    logic          accept;

    assign in_buf = cnt_reg < CW'(LED_COUNT);
    assign accept = start && (state_reg == S_IDLE);
    assign busy   = state_reg != S_IDLE;
    assign addr   = in_buf ? cnt_reg[AW-1:0] : '0;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    unique case (operation)
                        OP_CLEAR:   cmd.clear = 1'b1;
                        OP_SET:     cmd.set_entry = 1'b1;
                        OP_COMMIT:  state_next = S_COMMIT;
                        OP_SAVE:    state_next = S_SAVE;
                        OP_RESTORE: state_next = S_RESTORE;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_COMMIT:
            begin
                // Count k emits frame k; LED frames use the read issued at k-1.
                cmd.rd_work   = in_buf;
                cmd.emit      = 1'b1;
                cmd.emit_led  = (cnt_reg != '0) && (cnt_reg <= CW'(LED_COUNT));
                cmd.emit_last = cnt_reg == CW'(FRAMES - 1);
                if (cmd.emit_last)
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_SAVE:
            begin
                cmd.rd_work       = in_buf;
                cmd.copy_to_saved = in_buf;
                if (in_buf)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
            end
            S_RESTORE:
            begin
                cmd.rd_saved     = in_buf;
                cmd.copy_to_work = in_buf;
                if (in_buf)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_last_ends_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_last |=> (state_reg == S_IDLE) && (cnt_reg == '0))
        else $error("commit did not end after its last frame");

    a_idle_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !cmd.emit && !cmd.copy_to_saved && !cmd.copy_to_work)
        else $error("sweep command issued while idle");

    a_commit_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_COMMIT) |=> busy && cmd.emit && !cmd.emit_led)
        else $error("commit did not open with the start frame");

endmodule

/* sim/lsfb_checker.sv */
// Checker for the LED strip frame buffer streamer: watches the command and frame channels,
// keeps its own working and saved color buffers, and compares every frame beat in order.
// Depends on lsfb_pkg.
module lsfb_checker #(
    parameter int LED_COUNT = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [lsfb_pkg::OP_W-1:0]     operation,
    input  logic [lsfb_pkg::INDEX_W-1:0]  led_index,
    input  logic [lsfb_pkg::COLOR_W-1:0]  red,
    input  logic [lsfb_pkg::COLOR_W-1:0]  green,
    input  logic [lsfb_pkg::COLOR_W-1:0]  blue,
    input  logic [lsfb_pkg::BRIGHT_W-1:0] brightness,
    input  logic [lsfb_pkg::FRAME_W-1:0]  frame_word,
    input  logic                          last_frame,
    input  logic                          frame_strobe,
    output int                            mismatches,
    output int                            frames_pending,
    output int                            frames_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import lsfb_pkg::*;

    localparam int TAIL_FRAMES = (LED_COUNT + 63) / 64;

    typedef struct packed {
        frame_t word;
        logic   last;
    } frame_beat_t;

    entry_t      work_colors  [LED_COUNT];
    entry_t      saved_colors [LED_COUNT];
    frame_beat_t frame_queue  [$];

    // Commands are applied before frames are compared, so a frame that shows up in the
    // same cycle as the commit that causes it still finds its expectation.
    always @(posedge clk or negedge rst_n)
    begin
        frame_beat_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < LED_COUNT; i++)
            begin
                work_colors[i]  = '0;
                saved_colors[i] = '0;
            end
            frame_queue.delete();
            mismatches  = 0;
            frames_seen = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                case (operation)
                    OP_CLEAR:
                        for (int i = 0; i < LED_COUNT; i++)
                            work_colors[i] = '0;
                    OP_SET:
                        if (led_index < LED_COUNT)
                            work_colors[led_index] = {brightness, blue, green, red};
                    OP_COMMIT:
                    begin
                        frame_queue.push_back('{word: '0, last: 1'b0});
                        for (int i = 0; i < LED_COUNT; i++)
                            frame_queue.push_back('{word: {FRAME_TAG, work_colors[i]},
                                                    last: 1'b0});
                        frame_queue.push_back('{word: '0, last: (TAIL_FRAMES == 0)});
                        for (int i = 0; i < TAIL_FRAMES; i++)
                            frame_queue.push_back('{word: '0, last: (i == TAIL_FRAMES - 1)});
                    end
                    OP_SAVE:
                        saved_colors = work_colors;
                    OP_RESTORE:
                        work_colors = saved_colors;
                    default:
                        ;
                endcase
            end
            if (frame_strobe)
            begin
                if (frame_queue.size() == 0)
                begin
                    $display("%0t: unexpected frame beat %h last %b", $time, frame_word,
                             last_frame);
                    mismatches++;
                end
                else
                begin
                    want = frame_queue.pop_front();
                    if (frame_word !== want.word)
                    begin
                        $display("%0t: frame %0d word expected %h actual %h", $time,
                                 frames_seen, want.word, frame_word);
                        mismatches++;
                    end
                    if (last_frame !== want.last)
                    begin
                        $display("%0t: frame %0d last flag expected %b actual %b", $time,
                                 frames_seen, want.last, last_frame);
                        mismatches++;
                    end
                end
                frames_seen++;
            end
        end
        frames_pending = frame_queue.size();
    end

endmodule

/* sim/tb.sv */
// Top of the LED strip frame buffer streamer testbench: clock, reset, command stimulus,
// watchdog and verdict. Frames are predicted and checked in lsfb_checker.
// Depends on lsfb_pkg, lsfb_checker and led_strip_frame_buffer_streamer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lsfb_pkg::*;

    localparam int LED_COUNT      = 32;
    localparam int RANDOM_ITEMS   = 230;
    localparam int SETTLE_CYCLES  = LED_COUNT + 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // Codes above restore have no meaning and must leave both buffers alone.
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_RESTORE + 1'b1;
    localparam logic [OP_W-1:0] OP_LAST_CODE    = {OP_W{1'b1}};

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                start      = 1'b0;
    logic [OP_W-1:0]     operation  = OP_CLEAR;
    logic [INDEX_W-1:0]  led_index  = '0;
    logic [COLOR_W-1:0]  red        = '0;
    logic [COLOR_W-1:0]  green      = '0;
    logic [COLOR_W-1:0]  blue       = '0;
    logic [BRIGHT_W-1:0] brightness = '0;
    logic                busy;
    logic [FRAME_W-1:0]  frame_word;
    logic                last_frame;
    logic                frame_strobe;

    int mismatches;
    int frames_pending;
    int frames_seen;
    int idle_pct = 0;
    int quiet_cycles = 0;
    int op_count [1 << OP_W];

    always #10 clk = ~clk;

    led_strip_frame_buffer_streamer #(
        .LED_COUNT (LED_COUNT)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .led_index    (led_index),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .brightness   (brightness),
        .frame_word   (frame_word),
        .last_frame   (last_frame),
        .frame_strobe (frame_strobe)
    );

    lsfb_checker #(
        .LED_COUNT (LED_COUNT)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .led_index      (led_index),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .brightness     (brightness),
        .frame_word     (frame_word),
        .last_frame     (last_frame),
        .frame_strobe   (frame_strobe),
        .mismatches     (mismatches),
        .frames_pending (frames_pending),
        .frames_seen    (frames_seen)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || frame_strobe)
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Returns at the edge that takes the command. Start is left high so that a following
    // command can go out back to back; idle cycles carry junk on the fields.
    task automatic send_command(input logic [OP_W-1:0]     op,
                                input logic [INDEX_W-1:0]  idx,
                                input logic [COLOR_W-1:0]  r,
                                input logic [COLOR_W-1:0]  g,
                                input logic [COLOR_W-1:0]  b,
                                input logic [BRIGHT_W-1:0] br);
        while ($urandom_range(99) < idle_pct)
        begin
            start      <= 1'b0;
            operation  <= OP_W'($urandom);
            led_index  <= INDEX_W'($urandom);
            red        <= COLOR_W'($urandom);
            green      <= COLOR_W'($urandom);
            blue       <= COLOR_W'($urandom);
            brightness <= BRIGHT_W'($urandom);
            @(posedge clk);
        end
        start      <= 1'b1;
        operation  <= op;
        led_index  <= idx;
        red        <= r;
        green      <= g;
        blue       <= b;
        brightness <= br;
        do @(posedge clk); while (busy);
        op_count[op]++;
    endtask

    // Sends a command whose index and color fields carry random junk.
    task automatic send_op(input logic [OP_W-1:0] op);
        send_command(op, INDEX_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom),
                     COLOR_W'($urandom), BRIGHT_W'($urandom));
    endtask

    initial
    begin
        int useful;
        int pick;
        logic [OP_W-1:0] op;
        int phase_idle [3];

        phase_idle = '{0, 65, 9};
        foreach (op_count[i])
            op_count[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: commit of the cleared board, field extremes, alternating bit
        // patterns, the unused codes, and save, clear and restore around commits.
        send_command(OP_COMMIT, '1, '1, '1, '1, '1);
        send_command(OP_SET, 5'd0, 8'hFF, 8'hFF, 8'hFF, 5'h1F);
        send_command(OP_SET, 5'd31, 8'h01, 8'h80, 8'hFE, 5'h10);
        send_command(OP_SET, 5'd10, 8'hAA, 8'h55, 8'hAA, 5'h15);
        send_command(OP_SET, 5'd21, 8'h55, 8'hAA, 8'h55, 5'h0A);
        send_command(OP_SET, 5'd3, 8'h00, 8'h00, 8'h00, 5'h00);
        send_op(OP_FIRST_UNUSED);
        send_command(OP_FIRST_UNUSED + 1'b1, 5'd4, 8'hFF, 8'hFF, 8'hFF, 5'h1F);
        send_op(OP_LAST_CODE);
        send_command(OP_COMMIT, '0, '0, '0, '0, '0);
        send_op(OP_SAVE);
        send_command(OP_CLEAR, '1, '1, '1, '1, '1);
        send_op(OP_COMMIT);
        send_op(OP_RESTORE);
        send_op(OP_COMMIT);
        send_command(OP_SET, 5'd0, 8'h00, 8'h00, 8'h00, 5'h00);
        send_op(OP_COMMIT);
        send_op(OP_RESTORE);
        send_op(OP_SAVE);
        send_op(OP_COMMIT);
        send_op(OP_COMMIT);

        // Random: mostly color writes with a commit every few commands, in three
        // phases of sender idling. Unused codes do not count toward the total.
        useful = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = phase_idle[phase];
            while (useful < (phase + 1) * RANDOM_ITEMS / 3)
            begin
                pick = $urandom_range(99);
                if (pick < 58)
                    op = OP_SET;
                else if (pick < 71)
                    op = OP_COMMIT;
                else if (pick < 79)
                    op = OP_SAVE;
                else if (pick < 87)
                    op = OP_RESTORE;
                else if (pick < 93)
                    op = OP_CLEAR;
                else
                    op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
                send_op(op);
                if (op <= OP_RESTORE)
                    useful++;
            end
        end
        start <= 1'b0;

        do @(negedge clk); while (frames_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d set, %0d commit, %0d clear, %0d save, %0d restore commands",
                 op_count[OP_SET], op_count[OP_COMMIT], op_count[OP_CLEAR],
                 op_count[OP_SAVE], op_count[OP_RESTORE]);
        $display("and %0d unused codes; %0d frame beats compared, %0d mismatches",
                 op_count[OP_FIRST_UNUSED] + op_count[OP_FIRST_UNUSED + 1'b1]
                 + op_count[OP_LAST_CODE], frames_seen, mismatches);
        if (mismatches == 0 && frames_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
